// ===== hw/rtl/block_free_stack_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Block free-stack allocator assertion macros
// Shared forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BLOCK_FREE_STACK_ALLOCATOR_TOP_MACROS_SVH
`define BLOCK_FREE_STACK_ALLOCATOR_TOP_MACROS_SVH

// Property checked at every rising edge while reset is released.
`define BFSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after its trigger.
`define BFSA_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    `BFSA_ASSERT(label, clk, rst_n, (trig) |=> (cons), msg)

`endif

// ===== hw/rtl/bfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Block free-stack allocator package
// Field widths, command and status codes, FSM states and control structs.
// ----------------------------------------------------------------------------
package bfsa_pkg;

    localparam int BLOCK_W    = 10;
    localparam int BLOCK_SPAN = 1024;
    localparam int FC_W       = 11;
    localparam int CNT_W      = 32;

    typedef enum logic [1:0] {
        CMD_SEED  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_DOUBLE = 3'd2,
        ST_REJECT = 3'd3,
        ST_NULL   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_UPDATE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic map_read;
        logic commit;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
    } t_dp_status;

endpackage

// ===== hw/rtl/bfsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Block free-stack allocator controller
// Sequences the map clearing pass and the capture, lookup and update steps
// of each request, and owns the result valid flag.
// ----------------------------------------------------------------------------
module bfsa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  logic                  i_stall,
    input  bfsa_pkg::t_dp_status  i_dp_status,
    output bfsa_pkg::t_ctl_cmd    o_ctl_cmd
);
    import bfsa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_dp_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_ctl_cmd = '0;
        o_stall   = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_stall           = 1'b0;
                o_ctl_cmd.capture = i_valid;
            end
            S_MAP: begin
                o_ctl_cmd.map_read = 1'b1;
            end
            S_UPDATE: begin
                o_ctl_cmd.commit = out_free;
            end
            default: begin
                o_ctl_cmd = '0;
            end
        endcase
    end

    // Result valid flag: set on commit, cleared when the result is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== hw/rtl/bfsa_datapath.sv =====
// ----------------------------------------------------------------------------
// Block free-stack allocator datapath
// Holds the free stack memory, the used-block map memory, the stack pointer,
// the counters and the result registers.
// ----------------------------------------------------------------------------
module bfsa_datapath #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int STACK_DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bfsa_pkg::t_ctl_cmd                    i_ctl_cmd,
    output bfsa_pkg::t_dp_status                  o_dp_status,
    input  logic [1:0]                            i_cmd,
    input  logic [bfsa_pkg::BLOCK_W-1:0]          i_block,
    input  logic                                  i_in_use,
    input  logic                                  i_length,
    output logic [bfsa_pkg::BLOCK_W-1:0]          o_block_out,
    output logic [2:0]                            o_status,
    output logic [bfsa_pkg::FC_W-1:0]             o_free_count,
    output logic [bfsa_pkg::CNT_W-1:0]            o_alloc_successes,
    output logic [bfsa_pkg::CNT_W-1:0]            o_alloc_failures,
    output logic [bfsa_pkg::CNT_W-1:0]            o_free_total
);
    import bfsa_pkg::*;

    localparam int TOP_W     = $clog2(STACK_DEPTH + 1);
    localparam int SADDR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MAP_DEPTH = (NUM_BLOCKS < BLOCK_SPAN) ? NUM_BLOCKS : BLOCK_SPAN;
    localparam int MADDR_W   = $clog2(MAP_DEPTH);
    localparam logic [16:0]      NUM_BLOCKS_L = 17'(NUM_BLOCKS);
    localparam logic [TOP_W-1:0] TOP_FULL     = TOP_W'(STACK_DEPTH);
    localparam logic [TOP_W-1:0] TOP_ONE      = TOP_W'(1);
    localparam logic [MADDR_W-1:0] CLR_LAST   = MADDR_W'(MAP_DEPTH - 1);

    logic [BLOCK_W-1:0] stack_mem [STACK_DEPTH];
    logic               map_mem   [MAP_DEPTH];

    // Captured request.
    logic [1:0]          r_cmd;
    logic [BLOCK_W-1:0]  r_blk;
    logic                r_in_use;
    logic                r_length;

    // Memory read data and the map address used by the update.
    logic [BLOCK_W-1:0]  r_stk_q;
    logic                r_map_q;
    logic [MADDR_W-1:0]  r_map_addr;

    // Control state.
    logic [TOP_W-1:0]    r_top;
    logic [TOP_W-1:0]    n_top;
    logic [MADDR_W-1:0]  r_clr_addr;
    logic [CNT_W-1:0]    r_succ;
    logic [CNT_W-1:0]    r_fail;
    logic [CNT_W-1:0]    r_free;

    // Result payload.
    logic [BLOCK_W-1:0]  r_block_out;
    t_status             r_status;

    // Update decisions.
    logic [TOP_W-1:0]    top_m1;
    logic [BLOCK_W-1:0]  map_raddr;
    logic                blk_ok;
    logic                stk_empty;
    logic                stk_full;
    logic                do_push;
    logic                do_pop;
    logic                map_we;
    logic                map_wd;
    logic                inc_succ;
    logic                inc_fail;
    logic                inc_free;
    logic [BLOCK_W-1:0]  upd_blk_out;
    t_status             upd_status;
    logic [TOP_W+FC_W-1:0] top_ext;

    assign top_m1    = r_top - TOP_ONE;
    assign blk_ok    = {7'd0, r_blk} < NUM_BLOCKS_L;
    assign stk_empty = (r_top == '0);
    assign stk_full  = (r_top == TOP_FULL);
    assign map_raddr = (r_cmd == CMD_ALLOC) ? r_stk_q : r_blk;

    // Request capture, with the stack top read issued at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_ctl_cmd.capture) begin
            r_cmd    <= i_cmd;
            r_blk    <= i_block;
            r_in_use <= i_in_use;
            r_length <= i_length;
            r_stk_q  <= stack_mem[top_m1[SADDR_W-1:0]];
        end
    end

    // Free stack writes on push.
    always_ff @(posedge i_clk) begin
        if (i_ctl_cmd.commit && do_push) begin
            stack_mem[r_top[SADDR_W-1:0]] <= r_blk;
        end
    end

    // Used map: clearing pass or update write, and the lookup read.
    always_ff @(posedge i_clk) begin
        if (i_ctl_cmd.clear) begin
            map_mem[r_clr_addr] <= 1'b0;
        end else if (i_ctl_cmd.commit && map_we) begin
            map_mem[r_map_addr] <= map_wd;
        end
        if (i_ctl_cmd.map_read) begin
            r_map_q    <= map_mem[map_raddr[MADDR_W-1:0]];
            r_map_addr <= map_raddr[MADDR_W-1:0];
        end
    end

    // Per-command update decisions.
    always_comb begin
        do_push     = 1'b0;
        do_pop      = 1'b0;
        map_we      = 1'b0;
        map_wd      = 1'b0;
        inc_succ    = 1'b0;
        inc_fail    = 1'b0;
        inc_free    = 1'b0;
        upd_blk_out = '0;
        upd_status  = ST_REJECT;
        unique case (r_cmd)
            CMD_SEED: begin
                if (blk_ok) begin
                    if (r_in_use) begin
                        map_we     = 1'b1;
                        map_wd     = 1'b1;
                        upd_status = ST_OK;
                    end else if (!stk_full) begin
                        do_push    = 1'b1;
                        upd_status = ST_OK;
                    end
                end
            end
            CMD_ALLOC: begin
                if (stk_empty) begin
                    inc_fail   = 1'b1;
                    upd_status = ST_EMPTY;
                end else begin
                    do_pop      = 1'b1;
                    inc_succ    = 1'b1;
                    map_we      = 1'b1;
                    map_wd      = 1'b1;
                    upd_blk_out = r_stk_q;
                    upd_status  = r_map_q ? ST_DOUBLE : ST_OK;
                end
            end
            CMD_FREE: begin
                if (!r_length) begin
                    upd_status = ST_NULL;
                end else if (blk_ok && r_map_q && !stk_full) begin
                    do_push    = 1'b1;
                    map_we     = 1'b1;
                    map_wd     = 1'b0;
                    inc_free   = 1'b1;
                    upd_status = ST_OK;
                end
            end
            default: begin
                upd_status = ST_REJECT;
            end
        endcase
    end

    // Next stack pointer.
    always_comb begin
        n_top = r_top;
        if (i_ctl_cmd.commit) begin
            if (do_push) begin
                n_top = r_top + TOP_ONE;
            end else if (do_pop) begin
                n_top = top_m1;
            end
        end
    end

    // Stack pointer, clearing address and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top      <= '0;
            r_clr_addr <= '0;
            r_succ     <= '0;
            r_fail     <= '0;
            r_free     <= '0;
        end else begin
            r_top <= n_top;
            if (i_ctl_cmd.clear) begin
                r_clr_addr <= r_clr_addr + MADDR_W'(1);
            end
            if (i_ctl_cmd.commit) begin
                r_succ <= r_succ + CNT_W'(inc_succ);
                r_fail <= r_fail + CNT_W'(inc_fail);
                r_free <= r_free + CNT_W'(inc_free);
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl_cmd.commit) begin
            r_block_out <= upd_blk_out;
            r_status    <= upd_status;
        end
    end

    assign o_dp_status.clear_done = (r_clr_addr == CLR_LAST);

    assign top_ext           = {{FC_W{1'b0}}, r_top};
    assign o_block_out       = r_block_out;
    assign o_status          = r_status;
    assign o_free_count      = top_ext[FC_W-1:0];
    assign o_alloc_successes = r_succ;
    assign o_alloc_failures  = r_fail;
    assign o_free_total      = r_free;

endmodule

// ===== hw/rtl/block_free_stack_allocator_top.sv =====
// A request is accepted from the idle state; its result is registered by the update step.
// Each request goes through stack read, map read, and map and stack update before the next.
// A waiting result does not block acceptance; a second result waits in the update step.
// Reset is synchronous, active low; afterwards the used map is cleared one entry a
// cycle, all min(NUM_BLOCKS, 1024) entries, with o_stall high until the pass ends.
// ----------------------------------------------------------------------------
// Block free-stack allocator top level
// Single-block allocator with a LIFO free stack and a used-block map.
// ----------------------------------------------------------------------------
module block_free_stack_allocator_top #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int STACK_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [bfsa_pkg::BLOCK_W-1:0]  i_block,
    input  logic                          i_in_use,
    input  logic                          i_length,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bfsa_pkg::BLOCK_W-1:0]  o_block_out,
    output logic [2:0]                    o_status,
    output logic [bfsa_pkg::FC_W-1:0]     o_free_count,
    output logic [bfsa_pkg::CNT_W-1:0]    o_alloc_successes,
    output logic [bfsa_pkg::CNT_W-1:0]    o_alloc_failures,
    output logic [bfsa_pkg::CNT_W-1:0]    o_free_total
);
    import bfsa_pkg::*;

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;

    // Request sequencing.
    bfsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_dp_status (dp_status),
        .o_ctl_cmd   (ctl_cmd)
    );

    // Stack, map, counters and result registers.
    bfsa_datapath #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl_cmd         (ctl_cmd),
        .o_dp_status       (dp_status),
        .i_cmd             (i_cmd),
        .i_block           (i_block),
        .i_in_use          (i_in_use),
        .i_length          (i_length),
        .o_block_out       (o_block_out),
        .o_status          (o_status),
        .o_free_count      (o_free_count),
        .o_alloc_successes (o_alloc_successes),
        .o_alloc_failures  (o_alloc_failures),
        .o_free_total      (o_free_total)
    );

endmodule

// ===== hw/rtl/bfsa_checker.sv =====
// ----------------------------------------------------------------------------
// Block free-stack allocator port checker
// Watches the top-level ports and checks request and result behavior.
// ----------------------------------------------------------------------------
`include "block_free_stack_allocator_top_macros.svh"

module bfsa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [bfsa_pkg::BLOCK_W-1:0]  o_block_out,
    input  logic [2:0]                    o_status,
    input  logic [bfsa_pkg::FC_W-1:0]     o_free_count,
    input  logic [bfsa_pkg::CNT_W-1:0]    o_alloc_successes,
    input  logic [bfsa_pkg::CNT_W-1:0]    o_alloc_failures,
    input  logic [bfsa_pkg::CNT_W-1:0]    o_free_total
);
    import bfsa_pkg::*;

    logic                                req_take;
    logic                                other_res;
    logic                                empty_res;
    logic                                res_wait;
    logic [BLOCK_W+FC_W+3*CNT_W+3:0]     res_bus;

    // Handshake and result conditions watched by the properties.
    assign req_take  = i_valid && !o_stall;
    assign other_res = o_valid && (o_status != ST_OK) && (o_status != ST_DOUBLE);
    assign empty_res = o_valid && (o_status == ST_EMPTY);
    assign res_wait  = o_valid && i_stall;
    assign res_bus   = {o_valid, o_block_out, o_status, o_free_count,
                        o_alloc_successes, o_alloc_failures, o_free_total};

    // One request at a time: the block is busy right after taking one.
    `BFSA_ASSERT_NEXT(a_busy, i_clk, i_rst_n, req_take, o_stall, "accepted while busy")

    // A result with a status other than OK or DOUBLE carries a zero block.
    `BFSA_ASSERT(a_block_zero, i_clk, i_rst_n, other_res |-> o_block_out == '0, "nonzero block")

    // An empty result means the free stack really is empty.
    `BFSA_ASSERT(a_empty, i_clk, i_rst_n, empty_res |-> o_free_count == '0, "stack not empty")

    // A stalled result stays valid and holds its payload.
    `BFSA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, res_wait, $stable(res_bus), "result changed")

endmodule

bind block_free_stack_allocator_top bfsa_checker u_bfsa_checker (.*);

// ===== sim/block_free_stack_allocator_top_test.sv =====
// ----------------------------------------------------------------------------
// Block free-stack allocator testbench
// Drives seed, allocate and free requests through the valid/stall handshake.
// A scoreboard keeps its own free stack, used map and counters, and checks
// every result in order. Runs a directed opening, then random traffic with
// long output back-pressure, a fill of the stack to the top and a long drain.
// ----------------------------------------------------------------------------
import bfsa_pkg::*;

localparam int STACK_SLOTS = 1024;

// Command code that the block must reject.
localparam logic [1:0] CMD_UNUSED = 2'd3;

typedef struct {
    logic [BLOCK_W-1:0] blk;
    t_status            status;
    logic [FC_W-1:0]    free_cnt;
    logic [CNT_W-1:0]   grants;
    logic [CNT_W-1:0]   refusals;
    logic [CNT_W-1:0]   releases;
} t_alloc_reply;

class alloc_scoreboard;
    logic [BLOCK_W-1:0] stack_mem [STACK_SLOTS];
    logic [FC_W-1:0]    stack_top = '0;
    bit                 marked [BLOCK_SPAN];
    logic [CNT_W-1:0]   grants = '0;
    logic [CNT_W-1:0]   refusals = '0;
    logic [CNT_W-1:0]   releases = '0;
    t_alloc_reply       owed_replies [$];
    int unsigned        errors = 0;

    function int pending();
        return owed_replies.size();
    endfunction

    // Picks a block that is marked used, falling back to a random one.
    function logic [BLOCK_W-1:0] marked_block();
        logic [BLOCK_W-1:0] b;
        b = '0;
        for (int n = 0; n < 64; n++) begin
            b = BLOCK_W'($urandom_range(0, BLOCK_SPAN - 1));
            if (marked[b]) begin
                return b;
            end
        end
        return b;
    endfunction

    // Applies one accepted request to the allocator state and queues its reply.
    function void note_request(logic [1:0] cmd, logic [BLOCK_W-1:0] blk,
                               logic in_use, logic length);
        t_alloc_reply r;
        r.blk    = '0;
        r.status = ST_REJECT;
        case (cmd)
            CMD_SEED: begin
                if (int'(blk) < BLOCK_SPAN) begin
                    if (in_use) begin
                        marked[blk] = 1'b1;
                        r.status    = ST_OK;
                    end else if (stack_top < STACK_SLOTS) begin
                        stack_mem[stack_top] = blk;
                        stack_top++;
                        r.status = ST_OK;
                    end
                end
            end
            CMD_ALLOC: begin
                if (stack_top == 0) begin
                    refusals++;
                    r.status = ST_EMPTY;
                end else begin
                    stack_top--;
                    r.blk    = stack_mem[stack_top];
                    grants++;
                    r.status = marked[r.blk] ? ST_DOUBLE : ST_OK;
                    marked[r.blk] = 1'b1;
                end
            end
            CMD_FREE: begin
                if (!length) begin
                    r.status = ST_NULL;
                end else if (int'(blk) < BLOCK_SPAN && marked[blk] &&
                             stack_top < STACK_SLOTS) begin
                    stack_mem[stack_top] = blk;
                    stack_top++;
                    marked[blk] = 1'b0;
                    releases++;
                    r.status = ST_OK;
                end
            end
            default: begin
            end
        endcase
        r.free_cnt = stack_top;
        r.grants   = grants;
        r.refusals = refusals;
        r.releases = releases;
        owed_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] want,
                                logic [CNT_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Compares one accepted result with the oldest reply still owed.
    function void check_result(logic [BLOCK_W-1:0] blk, logic [2:0] status,
                               logic [FC_W-1:0] free_cnt, logic [CNT_W-1:0] succ,
                               logic [CNT_W-1:0] fail, logic [CNT_W-1:0] frees);
        t_alloc_reply r;
        if (owed_replies.size() == 0) begin
            errors++;
            $display("%0t: result with no request outstanding, expected none, %s %0d %s %0d",
                     $time, "actual block", blk, "status", status);
            return;
        end
        r = owed_replies.pop_front();
        compare_field("block_out", CNT_W'(r.blk), CNT_W'(blk));
        compare_field("status", CNT_W'(r.status), CNT_W'(status));
        compare_field("free_count", CNT_W'(r.free_cnt), CNT_W'(free_cnt));
        compare_field("alloc_successes", r.grants, succ);
        compare_field("alloc_failures", r.refusals, fail);
        compare_field("free_total", r.releases, frees);
    endfunction
endclass

module block_free_stack_allocator_top_test;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_cmd = '0;
    logic [BLOCK_W-1:0] i_block = '0;
    logic               i_in_use = 1'b0;
    logic               i_length = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [BLOCK_W-1:0] o_block_out;
    logic [2:0]         o_status;
    logic [FC_W-1:0]    o_free_count;
    logic [CNT_W-1:0]   o_alloc_successes;
    logic [CNT_W-1:0]   o_alloc_failures;
    logic [CNT_W-1:0]   o_free_total;

    alloc_scoreboard sb = new();
    int unsigned     burst_left = 0;
    bit              eager = 1'b0;
    bit              hold_pending = 1'b0;

    block_free_stack_allocator_top #(
        .NUM_BLOCKS (BLOCK_SPAN),
        .STACK_DEPTH(STACK_SLOTS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_block          (i_block),
        .i_in_use         (i_in_use),
        .i_length         (i_length),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_block_out      (o_block_out),
        .o_status         (o_status),
        .o_free_count     (o_free_count),
        .o_alloc_successes(o_alloc_successes),
        .o_alloc_failures (o_alloc_failures),
        .o_free_total     (o_free_total)
    );

    always #1 i_clk = ~i_clk;

    // Both handshakes are sampled at the rising edge, before any update lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_request(i_cmd, i_block, i_in_use, i_length);
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_block_out, o_status, o_free_count,
                                o_alloc_successes, o_alloc_failures, o_free_total);
            end
        end
    end

    // Offers one request and returns at the edge where it is accepted.
    // The sender works in bursts with random gaps between them.
    task automatic send_request(logic [1:0] cmd, logic [BLOCK_W-1:0] blk,
                                logic in_use, logic length);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = (eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_cmd    <= cmd;
        i_block  <= blk;
        i_in_use <= in_use;
        i_length <= length;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stops offering until every owed reply has come back. The first edge
    // lets the monitor note the request accepted at the calling edge.
    task automatic wait_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Mostly well-formed traffic: allocations and frees of used blocks,
    // with seeds, null frees and rejected requests mixed in.
    task automatic random_request();
        int unsigned        pick;
        logic [BLOCK_W-1:0] blk;
        logic               b0;
        logic               b1;
        pick = $urandom_range(0, 99);
        blk  = BLOCK_W'($urandom_range(0, BLOCK_SPAN - 1));
        b0   = 1'($urandom_range(0, 1));
        b1   = 1'($urandom_range(0, 1));
        if (pick < 30) begin
            send_request(CMD_ALLOC, blk, b0, b1);
        end else if (pick < 60) begin
            send_request(CMD_FREE, sb.marked_block(), b0, 1'b1);
        end else if (pick < 75) begin
            send_request(CMD_SEED, blk, 1'b0, b1);
        end else if (pick < 83) begin
            send_request(CMD_SEED, blk, 1'b1, b1);
        end else if (pick < 88) begin
            send_request(CMD_FREE, blk, b0, b1);
        end else if (pick < 93) begin
            send_request(CMD_FREE, blk, b0, 1'b0);
        end else if (pick < 97) begin
            send_request(CMD_UNUSED, blk, b0, b1);
        end else begin
            send_request(CMD_SEED, blk, b0, b1);
        end
    endtask

    // Receiver stall patterns, with a long hold whenever one is requested.
    initial begin
        int mode;
        int span;
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 150);
                for (int k = 0; k < span; k++) begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= 1'($urandom_range(0, 1));
                        2: i_stall <= ($urandom_range(0, 3) != 0);
                        default: i_stall <= (k % 4 == 1);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int needed;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty stack, null and rejected frees, the unused
        // command, extreme block numbers and a double allocation.
        send_request(CMD_ALLOC, 10'd0, 1'b0, 1'b0);
        send_request(CMD_FREE, 10'd1023, 1'b1, 1'b0);
        send_request(CMD_FREE, 10'd5, 1'b0, 1'b1);
        send_request(CMD_UNUSED, 10'd1023, 1'b1, 1'b1);
        send_request(CMD_SEED, 10'd0, 1'b0, 1'b0);
        send_request(CMD_SEED, 10'd1023, 1'b0, 1'b1);
        send_request(CMD_SEED, 10'd1023, 1'b1, 1'b0);
        send_request(CMD_ALLOC, 10'd1023, 1'b1, 1'b1);
        send_request(CMD_ALLOC, 10'd0, 1'b0, 1'b0);
        send_request(CMD_ALLOC, 10'd0, 1'b0, 1'b0);
        send_request(CMD_FREE, 10'd0, 1'b0, 1'b1);
        send_request(CMD_FREE, 10'd0, 1'b0, 1'b1);
        send_request(CMD_FREE, 10'd1023, 1'b0, 1'b1);
        send_request(CMD_SEED, 10'd0, 1'b1, 1'b1);
        send_request(CMD_ALLOC, 10'd0, 1'b0, 1'b0);
        send_request(CMD_ALLOC, 10'd0, 1'b0, 1'b0);
        send_request(CMD_FREE, 10'd0, 1'b1, 1'b0);
        send_request(CMD_SEED, 10'd512, 1'b1, 1'b0);
        send_request(CMD_FREE, 10'd512, 1'b0, 1'b1);
        send_request(CMD_ALLOC, 10'd0, 1'b0, 1'b0);
        send_request(CMD_FREE, 10'd1023, 1'b0, 1'b1);
        send_request(CMD_FREE, 10'd0, 1'b0, 1'b1);
        send_request(CMD_FREE, 10'd512, 1'b0, 1'b1);

        // Random traffic; a long receiver hold while the sender keeps offering.
        for (int n = 0; n < 300; n++) begin
            if (n == 50) begin
                hold_pending = 1'b1;
                eager        = 1'b1;
            end
            if (n == 250) begin
                eager = 1'b0;
            end
            random_request();
        end

        // Fill the stack to the top, then push and free against a full stack.
        wait_drained();
        send_request(CMD_SEED, 10'd7, 1'b1, 1'b0);
        send_request(CMD_SEED, 10'd700, 1'b1, 1'b0);
        wait_drained();
        needed = STACK_SLOTS - int'(sb.stack_top);
        for (int n = 0; n < needed; n++) begin
            send_request(CMD_SEED, BLOCK_W'($urandom_range(0, BLOCK_SPAN - 1)),
                         1'b0, 1'($urandom_range(0, 1)));
        end
        send_request(CMD_SEED, 10'd3, 1'b0, 1'b0);
        send_request(CMD_SEED, 10'd1023, 1'b0, 1'b1);
        send_request(CMD_FREE, 10'd7, 1'b0, 1'b1);
        send_request(CMD_FREE, 10'd700, 1'b1, 1'b1);
        send_request(CMD_SEED, 10'd9, 1'b1, 1'b0);

        // Long run of allocations from the full stack.
        for (int n = 0; n < 600; n++) begin
            send_request(CMD_ALLOC, BLOCK_W'($urandom_range(0, BLOCK_SPAN - 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        for (int n = 0; n < 100; n++) begin
            random_request();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** block_free_stack_allocator_top: PASSED **");
        end else begin
            $display("** block_free_stack_allocator_top: FAILED **");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("** block_free_stack_allocator_top: FAILED **");
        $finish;
    end

endmodule
